// ===== sv/two_class_priority_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Two-class priority queue assertion macros
// Shared property shorthands, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_PRIORITY_QUEUE_MACROS_SVH
`define TWO_CLASS_PRIORITY_QUEUE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TCPQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tcpq assertion failed");

// consequent must hold in the cycle after the antecedent
`define TCPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tcpq assertion failed");

`endif

// ===== sv/tcpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-class priority queue package
// Field widths, command and status codes, and the cell control types.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    localparam int KEY_W      = 16;
    localparam int PRIO_W     = 8;
    localparam int THR_W      = 8;
    localparam int OCC_W      = 5;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd60;
    localparam logic             REG_THRESHOLD   = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_SERVE  = 2'd1,
        CMD_CANCEL = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             pref;
    } t_slot;

    // broadcast to every cell of the row
    typedef struct packed {
        logic             ins_pref;
        logic             ins_norm;
        logic             remove;
    } t_cell_ctl;

endpackage

// ===== sv/tcpq_cell.sv =====
// ----------------------------------------------------------------------------
// Two-class priority queue cell
// Holds one queue slot; compares its key and shifts to or from its neighbours.
// ----------------------------------------------------------------------------
module tcpq_cell #(
    parameter int IDX_W = 4,
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  logic                  i_clk,
    input  tcpq_pkg::t_cell_ctl   i_ctl,
    input  logic [tcpq_pkg::KEY_W-1:0] i_key,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [IDX_W-1:0]      i_rm_pos,
    input  tcpq_pkg::t_slot       i_left,
    input  logic                  i_left_valid,
    input  tcpq_pkg::t_slot       i_right,
    output tcpq_pkg::t_slot       o_slot,
    output logic                  o_valid,
    output logic                  o_match
);
    import tcpq_pkg::*;

    t_slot r_slot;
    t_slot n_slot;
    logic  w_valid;
    logic  w_before;
    logic  w_at_or_after_rm;

    assign w_valid          = CNT_W'(IDX) < i_count;
    assign o_match          = w_valid && (r_slot.key == i_key);
    // preferred entries stay put on a preferred insert
    assign w_before         = w_valid && r_slot.pref;
    assign w_at_or_after_rm = IDX_W'(IDX) >= i_rm_pos;

    always_comb begin
        n_slot = r_slot;
        priority if (i_ctl.remove) begin
            if (w_at_or_after_rm) begin
                n_slot = i_right;
            end
        end else if (i_ctl.ins_pref) begin
            if (!w_before) begin
                if (i_left_valid && i_left.pref) begin
                    n_slot = '{key: i_key, pref: 1'b1};
                end else begin
                    n_slot = i_left;
                end
            end
        end else if (i_ctl.ins_norm) begin
            if (!w_valid && i_left_valid) begin
                n_slot = '{key: i_key, pref: 1'b0};
            end
        end else begin
            n_slot = r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot  = r_slot;
    assign o_valid = w_valid;

endmodule

// ===== sv/two_class_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Two-class priority queue
// Bounded id queue with a preferred and a normal section, serve and cancel.
// ----------------------------------------------------------------------------
// One command is taken per clock and its result appears in the output register
// on the next cycle; with the output not stalled the block sustains one command
// every cycle. Each command is finished in the cycle it is taken by the row of
// CAPACITY cells: all cells compare the id at once, and each cell keeps its slot or
// loads from its left or right neighbour or from the command to open or close a gap.
// Preferred entries (priority value at or above the threshold register) sit
// ahead of normal ones, and each section is first in, first out. The register
// pref_threshold lies at byte address 0 and resets to 60.
module two_class_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [tcpq_pkg::CMD_W-1:0]        i_cmd,
    input  logic [tcpq_pkg::KEY_W-1:0]        i_entry_key,
    input  logic [tcpq_pkg::PRIO_W-1:0]       i_prio_value,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [tcpq_pkg::STATUS_W-1:0]     o_status,
    output logic [tcpq_pkg::KEY_W-1:0]        o_served_key,
    output logic [tcpq_pkg::OCC_W-1:0]        o_occupancy,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcpq_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tcpq_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tcpq_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import tcpq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [CNT_W-1:0]    r_pref_count;
    logic [CNT_W-1:0]    n_pref_count;
    logic [THR_W-1:0]    r_threshold;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [KEY_W-1:0]    r_served;
    logic [OCC_W-1:0]    r_occupancy;

    t_status             w_status;
    logic [KEY_W-1:0]    w_served;
    t_cell_ctl           w_cmd_ctl;
    t_cell_ctl           w_ctl;
    logic [IDX_W-1:0]    w_rm_pos;
    logic [IDX_W-1:0]    w_hit_pos;
    logic                w_hit_pref;
    logic                w_any_match;
    logic                w_accept;
    logic                w_cfg_write;

    t_slot               w_slot  [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_match;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign w_ctl       = w_accept ? w_cmd_ctl : '0;

    // ---- cell row ----
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_slot w_left;
        t_slot w_right;
        logic  w_left_valid;

        if (gi == 0) begin : g_head
            // the head sees a preferred neighbour so a preferred insert lands here unless the head is preferred
            assign w_left       = '{key: '0, pref: 1'b1};
            assign w_left_valid = 1'b1;
        end else begin : g_body
            assign w_left       = w_slot[gi-1];
            assign w_left_valid = w_valid[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_tail
            assign w_right = w_slot[gi];
        end else begin : g_inner
            assign w_right = w_slot[gi+1];
        end

        tcpq_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .IDX   (gi)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_key        (i_entry_key),
            .i_count      (r_count),
            .i_rm_pos     (w_rm_pos),
            .i_left       (w_left),
            .i_left_valid (w_left_valid),
            .i_right      (w_right),
            .o_slot       (w_slot[gi]),
            .o_valid      (w_valid[gi]),
            .o_match      (w_match[gi])
        );
    end

    // ids are unique in the queue, so at most one cell matches
    always_comb begin
        w_hit_pos  = '0;
        w_hit_pref = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_match[i]) begin
                w_hit_pos  = w_hit_pos | IDX_W'(i);
                w_hit_pref = w_hit_pref | w_slot[i].pref;
            end
        end
    end

    assign w_any_match = |w_match;

    // ---- command decode ----
    always_comb begin
        w_status     = ST_OK;
        w_served     = '0;
        w_cmd_ctl    = '{ins_pref: 1'b0, ins_norm: 1'b0, remove: 1'b0};
        w_rm_pos     = w_hit_pos;
        n_count      = r_count;
        n_pref_count = r_pref_count;
        unique case (i_cmd)
            CMD_INSERT: begin
                if (w_any_match) begin
                    w_status = ST_DUPLICATE;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    w_status = ST_FULL;
                end else if (i_prio_value >= r_threshold) begin
                    w_cmd_ctl.ins_pref = 1'b1;
                    n_count            = r_count + CNT_W'(1);
                    n_pref_count       = r_pref_count + CNT_W'(1);
                end else begin
                    w_cmd_ctl.ins_norm = 1'b1;
                    n_count            = r_count + CNT_W'(1);
                end
            end
            CMD_SERVE: begin
                w_rm_pos = '0;
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_cmd_ctl.remove = 1'b1;
                    w_served         = w_slot[0].key;
                    n_count          = r_count - CNT_W'(1);
                    if (w_slot[0].pref) begin
                        n_pref_count = r_pref_count - CNT_W'(1);
                    end
                end
            end
            CMD_CANCEL: begin
                if (!w_any_match) begin
                    w_status = ST_NOT_FOUND;
                end else begin
                    w_cmd_ctl.remove = 1'b1;
                    n_count          = r_count - CNT_W'(1);
                    if (w_hit_pref) begin
                        n_pref_count = r_pref_count - CNT_W'(1);
                    end
                end
            end
            default: begin
                // unused code: no change
            end
        endcase
    end

    // ---- control state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pref_count <= '0;
            r_out_valid  <= 1'b0;
            r_threshold  <= THRESHOLD_RESET;
        end else begin
            if (w_accept) begin
                r_count      <= n_count;
                r_pref_count <= n_pref_count;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
            if (w_cfg_write && (paddr[2] == REG_THRESHOLD)) begin
                r_threshold <= pwdata[THR_W-1:0];
            end
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= w_status;
            r_served    <= w_served;
            r_occupancy <= OCC_W'(n_count);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_served_key = r_served;
    assign o_occupancy  = r_occupancy;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THRESHOLD)
                  ? {{(APB_DATA_W-THR_W){1'b0}}, r_threshold} : '0;

endmodule

// ===== sv/tcpq_checker.sv =====
// ----------------------------------------------------------------------------
// Two-class priority queue port checker
// Watches the top-level ports for result and handshake consistency.
// ----------------------------------------------------------------------------
`include "two_class_priority_queue_macros.svh"

module tcpq_checker #(
    parameter int CAPACITY = 16
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [tcpq_pkg::STATUS_W-1:0]     o_status,
    input logic [tcpq_pkg::KEY_W-1:0]        o_served_key,
    input logic [tcpq_pkg::OCC_W-1:0]        o_occupancy
);
    import tcpq_pkg::*;

    logic [STATUS_W+KEY_W+OCC_W-1:0] w_result;

    assign w_result = {o_status, o_served_key, o_occupancy};

    // every accepted command yields a result on the next cycle
    `TCPQ_ASSERT_NEXT(a_result_follows, i_in_valid && !o_in_stall, o_out_valid)

    // a served id only comes with an ok status
    `TCPQ_ASSERT_NOW(a_served_ok, o_out_valid && (o_served_key != '0), o_status == ST_OK)

    // occupancy never exceeds the queue size unless it wraps
    `TCPQ_ASSERT_NOW(a_occ_bound, o_out_valid, (CAPACITY > 31) || (o_occupancy <= CAPACITY))

    // a stalled result holds
    `TCPQ_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(w_result))

endmodule

bind two_class_priority_queue tcpq_checker #(.CAPACITY(CAPACITY)) u_tcpq_checker (.*);

// ===== sim/two_class_priority_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-class priority queue testbench
// Drives insert, serve and cancel commands with random gaps and output stalls.
// Every result is checked against a queue model kept alongside the block. The
// run steps through several threshold settings, the extremes among them.
// ----------------------------------------------------------------------------
module two_class_priority_queue_tb;
    import tcpq_pkg::*;

    localparam int                    CAPACITY   = 16;
    localparam int                    QUIET_MAX  = 2000;
    localparam int                    KEY_POOL   = 24;
    localparam logic [CMD_W-1:0]      CMD_UNUSED = 2'd3;
    localparam logic [APB_ADDR_W-1:0] THR_ADDR   = {REG_THRESHOLD, 2'b00};

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  key;
        logic [PRIO_W-1:0] prio;
    } t_queue_cmd;

    typedef struct packed {
        t_status           status;
        logic [KEY_W-1:0]  served_key;
        logic [OCC_W-1:0]  occupancy;
    } t_queue_result;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_stall;
    logic [CMD_W-1:0]      i_cmd        = '0;
    logic [KEY_W-1:0]      i_entry_key  = '0;
    logic [PRIO_W-1:0]     i_prio_value = '0;
    logic                  o_out_valid;
    logic                  i_out_stall  = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic [KEY_W-1:0]      o_served_key;
    logic [OCC_W-1:0]      o_occupancy;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    two_class_priority_queue #(.CAPACITY(CAPACITY)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // queue model: preferred entries first, then normal, each in arrival order
    t_slot         model_slots[$];
    int            model_pref_cnt  = 0;
    logic [7:0]    model_threshold = THRESHOLD_RESET;

    t_queue_cmd    cmd_pending[$];
    t_queue_result result_due[$];
    t_queue_result head_result;
    logic          cmd_fire_q   = 1'b0;
    logic          idle_on      = 1'b0;
    int            send_gap     = 0;
    int            stall_left   = 0;
    int            quiet_cycles = 0;
    int            errors       = 0;
    int            cmds_taken   = 0;
    int            results_seen = 0;
    int            full_seen    = 0;
    int            empty_seen   = 0;
    logic [KEY_W-1:0] key_pool[KEY_POOL];

    function automatic t_queue_result apply_queue_cmd(t_queue_cmd c);
        t_queue_result r;
        t_slot         s;
        int            pos;
        r.status     = ST_OK;
        r.served_key = '0;
        pos = -1;
        foreach (model_slots[i])
            if (pos < 0 && model_slots[i].key == c.key) pos = i;
        case (c.cmd)
            CMD_INSERT: begin
                if (pos >= 0) begin
                    r.status = ST_DUPLICATE;
                end else if (model_slots.size() >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    s.key  = c.key;
                    s.pref = (c.prio >= model_threshold);
                    if (s.pref) begin
                        model_slots.insert(model_pref_cnt, s);
                        model_pref_cnt++;
                    end else begin
                        model_slots.push_back(s);
                    end
                end
            end
            CMD_SERVE: begin
                if (model_slots.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.served_key = model_slots[0].key;
                    if (model_slots[0].pref) model_pref_cnt--;
                    void'(model_slots.pop_front());
                end
            end
            CMD_CANCEL: begin
                if (pos < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    if (model_slots[pos].pref) model_pref_cnt--;
                    model_slots.delete(pos);
                end
            end
            default: ;
        endcase
        r.occupancy = OCC_W'(model_slots.size());
        return r;
    endfunction

    // command driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && !cmd_fire_q)) begin
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (cmd_pending.size() > 0) begin
                if (idle_on && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 9);
                    i_in_valid <= 1'b0;
                end else begin
                    i_cmd        <= cmd_pending[0].cmd;
                    i_entry_key  <= cmd_pending[0].key;
                    i_prio_value <= cmd_pending[0].prio;
                    void'(cmd_pending.pop_front());
                    i_in_valid   <= 1'b1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result-side back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 9);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor: predict on each command transfer, check on each result transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_fire_q <= 1'b0;
        end else begin
            cmd_fire_q <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                result_due.push_back(apply_queue_cmd({i_cmd, i_entry_key, i_prio_value}));
                cmds_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (result_due.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    errors++;
                end else begin
                    head_result = result_due.pop_front();
                    if (head_result.status == ST_FULL)  full_seen++;
                    if (head_result.status == ST_EMPTY) empty_seen++;
                    if (o_status !== head_result.status) begin
                        $error("status: expected %0d, got %0d", head_result.status, o_status);
                        errors++;
                    end
                    if (o_served_key !== head_result.served_key) begin
                        $error("served_key: expected %h, got %h",
                               head_result.served_key, o_served_key);
                        errors++;
                    end
                    if (o_occupancy !== head_result.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               head_result.occupancy, o_occupancy);
                        errors++;
                    end
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("Timeout: no transfer for %0d cycles", QUIET_MAX);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic push_cmd(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k, logic [PRIO_W-1:0] p);
        cmd_pending.push_back({c, k, p});
    endtask

    task automatic wait_drained();
        while (cmd_pending.size() != 0 || i_in_valid || send_gap != 0 || result_due.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic threshold_readback();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= THR_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DATA_W'(model_threshold)) begin
            $error("pref_threshold: expected %0d, got %0d", model_threshold, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic threshold_write(logic [THR_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= THR_ADDR;
        pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        model_threshold = value;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        threshold_readback();
    endtask

    function automatic t_queue_cmd random_queue_cmd(int fill_bias);
        t_queue_cmd c;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            c.cmd = CMD_UNUSED;
        else if (pick < 2 + fill_bias)
            c.cmd = CMD_INSERT;
        else if ($urandom_range(0, 9) < 6)
            c.cmd = CMD_SERVE;
        else
            c.cmd = CMD_CANCEL;
        // mostly ids from a small pool so duplicates and cancel hits are common
        if ($urandom_range(0, 9) == 0)
            c.key = KEY_W'($urandom);
        else
            c.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        if ($urandom_range(0, 3) == 0)
            c.prio = model_threshold + PRIO_W'($urandom_range(0, 2)) - 8'd1;
        else
            c.prio = PRIO_W'($urandom);
        return c;
    endfunction

    initial begin
        logic [THR_W-1:0] thr_plan[6];
        int               fill_bias;
        int               n_items;
        thr_plan = '{8'd60, 8'd0, 8'd255, 8'd128, 8'($urandom), 8'($urandom)};
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        threshold_readback();

        // directed: empty queue, threshold boundary, duplicates, full queue
        push_cmd(CMD_SERVE,  16'h0000, 8'd0);
        push_cmd(CMD_CANCEL, 16'hffff, 8'd0);
        push_cmd(CMD_INSERT, 16'h0000, 8'd0);
        push_cmd(CMD_INSERT, 16'hffff, 8'd255);
        push_cmd(CMD_INSERT, 16'h1234, 8'd60);
        push_cmd(CMD_INSERT, 16'h4321, 8'd59);
        push_cmd(CMD_INSERT, 16'h0000, 8'd200);
        push_cmd(CMD_UNUSED, 16'h5a5a, 8'd77);
        push_cmd(CMD_CANCEL, 16'h1234, 8'd0);
        push_cmd(CMD_CANCEL, 16'haaaa, 8'd0);
        for (int i = 0; i < 13; i++)
            push_cmd(CMD_INSERT, 16'h0100 + 16'(i), 8'(i * 19));
        push_cmd(CMD_INSERT, 16'h7777, 8'd255);
        push_cmd(CMD_INSERT, 16'h4321, 8'd0);

        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                wait_drained();
                threshold_write(thr_plan[p]);
            end
            // one phase at full rate mid-run, and the last phase too
            idle_on = !(p == 3 || p == 5);
            n_items = (p == 5) ? 100 : 200;
            key_pool[0] = 16'h0000;
            key_pool[1] = 16'hffff;
            for (int k = 2; k < KEY_POOL; k++)
                key_pool[k] = KEY_W'($urandom);
            fill_bias = 70;
            for (int i = 0; i < n_items; i++) begin
                // alternate filling and draining runs to reach full and empty
                if (i % 40 == 0)
                    fill_bias = (fill_bias == 70) ? 25 : 70;
                cmd_pending.push_back(random_queue_cmd(fill_bias));
            end
        end

        wait_drained();
        repeat (5) @(posedge i_clk);
        $display("Run covered %0d commands and %0d results over 6 threshold settings",
                 cmds_taken, results_seen);
        $display("Full-queue refusals: %0d, serves on empty queue: %0d",
                 full_seen, empty_seen);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/tcpq_pkg.sv
sv/tcpq_cell.sv
sv/two_class_priority_queue.sv
sv/tcpq_checker.sv
sim/two_class_priority_queue_tb.sv
